// File: rtl/core/bc_pkg.sv
// Shared types and constants of the binomial coefficient core.
`timescale 1ns / 1ps
`default_nettype none

package bc_pkg;

	// Largest set size accepted (the 64-bit running value holds C(n,k) up to n = 67)
	localparam int MAX_N = 60;

	localparam int N_W     = 6;              // n_items and chosen
	localparam int R_W     = N_W - 1;        // reduced count, at most 31
	localparam int COEFF_W = 57;             // coefficient field
	localparam int ACC_W   = 64;             // running value
	localparam int PROD_W  = ACC_W + N_W;    // running value times (n - i)
	localparam int DEN_W   = N_W;            // divisor i + 1, at most 32
	localparam int REM_W   = DEN_W + 1;      // partial remainder of the divider
	localparam int CNT_W   = $clog2(PROD_W); // divider bit counter

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_R_ABOVE_N   = 2'd1,
		ST_N_ABOVE_MAX = 2'd2
	} bc_status_t;

	typedef struct packed {
		logic [N_W-1:0] n_items;
		logic [N_W-1:0] chosen;
	} bc_in_t;

	typedef struct packed {
		logic [COEFF_W-1:0] coefficient;
		bc_status_t         status;
	} bc_out_t;

	// Sequencer to divider
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [DEN_W-1:0]  divisor;
	} bc_div_req_t;

	// Divider to sequencer
	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quotient;
	} bc_div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/bc_div.sv
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bc_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bc_pkg::bc_div_req_t req,
	output bc_pkg::bc_div_rsp_t     rsp
);
	import bc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  divisor_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] dvs_ext;
	logic             fits;
	logic [REM_W-1:0] rem_n;

	// Shift in the next dividend bit, subtract when the divisor fits
	always_comb begin
		rem_sh  = {rem_q, quo_q[PROD_W-1]};
		dvs_ext = {1'b0, divisor_q};
		fits    = (rem_sh >= dvs_ext);
		rem_n   = fits ? (rem_sh - dvs_ext) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= rem_n[DEN_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[ACC_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/binomial_coefficient_core.sv
// Top level of the binomial coefficient core: sequencer, multiply and result register.
//
//   channel | direction | payload  | transaction when
//   --------+-----------+----------+----------------------------
//   req     | in        | bc_in_t  | req_valid && req_ready
//   rsp     | out       | bc_out_t | rsp_valid && rsp_ready
//
// One request at a time. With k = min(r, n - r), the request runs k rounds: each
// round is an S_STEP state that loads the 64x6 product into the divider, then
// S_DIV for the shift-subtract steps until the divider's done flag. After the
// last round S_STEP passes to S_FIN, which raises rsp_valid. Worst case with
// MAX_N = 60 is k = 30. Error and trivial cases run no round; the next request
// can be taken as soon as rsp_valid rises.
// arst_n clears the sequencer, the divider control and rsp_valid; no clearing pass.
// A stalled rsp holds its result. req_ready still returns in S_IDLE; the next
// request then runs and waits in S_FIN until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none

module binomial_coefficient_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire bc_pkg::bc_in_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output bc_pkg::bc_out_t     rsp
);
	import bc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_STEP = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} bc_state_t;

	bc_state_t        state_q;
	logic [N_W-1:0]   n_q;
	logic [R_W-1:0]   k_q;     // reduced count min(r, n - r)
	logic [R_W-1:0]   i_q;     // round index
	logic [ACC_W-1:0] acc_q;   // running value C(n, i)
	bc_status_t       status_q;
	logic             rsp_valid_q;
	bc_out_t          rsp_q;

	bc_div_req_t div_req;
	bc_div_rsp_t div_rsp;

	logic           req_acc;
	logic           rsp_free;
	logic [N_W-1:0] n_minus_r;
	logic [N_W-1:0] k_full;
	bc_status_t     status_in;
	logic           rounds_done;
	logic [N_W-1:0] factor;

	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// Classify the request and fold r onto the smaller side
	always_comb begin
		n_minus_r = req.n_items - req.chosen;
		if (req.chosen > req.n_items) begin
			status_in = ST_R_ABOVE_N;
		end else if (32'(req.n_items) > MAX_N) begin
			status_in = ST_N_ABOVE_MAX;
		end else begin
			status_in = ST_OK;
		end
		if (status_in != ST_OK) begin
			k_full = '0;
		end else if (req.chosen > n_minus_r) begin
			k_full = n_minus_r;
		end else begin
			k_full = req.chosen;
		end
	end

	assign rounds_done = (i_q == k_q);
	assign factor      = n_q - {1'b0, i_q};

	// Round: acc * (n - i), then divide exactly by (i + 1)
	always_comb begin
		div_req.start    = (state_q == S_STEP) && !rounds_done;
		div_req.dividend = PROD_W'(acc_q) * PROD_W'(factor);
		div_req.divisor  = {1'b0, i_q} + 1'b1;
	end

	bc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					state_q <= rounds_done ? S_FIN : S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_STEP;
					end
				end
				S_FIN: begin
					// Hold until the result register is free
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			n_q      <= req.n_items;
			k_q      <= k_full[R_W-1:0];
			i_q      <= '0;
			acc_q    <= ACC_W'(1);
			status_q <= status_in;
		end
		if ((state_q == S_DIV) && div_rsp.done) begin
			acc_q <= div_rsp.quotient;
			i_q   <= i_q + 1'b1;
		end
		if ((state_q == S_FIN) && rsp_free) begin
			rsp_q.status      <= status_q;
			rsp_q.coefficient <= (status_q == ST_OK) ? acc_q[COEFF_W-1:0] : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: rtl/core/bc_checker.sv
// Port-level checks of the binomial coefficient core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire bc_pkg::bc_in_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire bc_pkg::bc_out_t rsp
);
	import bc_pkg::*;

	// A stalled result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_R_ABOVE_N
			|| rsp.status == ST_N_ABOVE_MAX))
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.coefficient == '0)
		else $error("error result carries a coefficient");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OK |-> rsp.coefficient != '0)
		else $error("ok result with zero coefficient");

	// One transaction in flight: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

endmodule

bind binomial_coefficient_core bc_checker u_bc_checker (.*);

`default_nettype wire

// File: sim/tb_binomial_coefficient_core.sv
// Self-checking testbench for binomial_coefficient_core: directed and random n, r requests.
`timescale 1ns / 1ps

module tb_binomial_coefficient_core;

	import bc_pkg::*;

	localparam int          CLK_PERIOD   = 8;
	localparam int unsigned CYCLE_LIMIT  = 4_000_000;
	localparam int          DRAIN_CYCLES = 2500;      // longer than the slowest request
	localparam int          REPORT_MAX   = 10;

	// One accepted request together with the result it must produce
	typedef struct {
		bc_in_t  item;
		bc_out_t result;
	} pending_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_ready;
	bc_in_t  req       = '0;
	logic    rsp_valid;
	logic    rsp_ready = 1'b0;
	bc_out_t rsp;

	pending_t    pending_coefficients[$];
	pending_t    oldest;
	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned ready_hold     = 0;
	bit          no_idle        = 1'b0; // when set, requests get no gaps and ready stays high once a pending stall ends

	binomial_coefficient_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// C(n, r) by the multiplicative rule. Each step leaves C(n, i + 1) in the
	// running value, so the division is always exact; 128 bits leave plenty of
	// headroom for the product before the divide.
	function automatic bc_out_t binomial_of(input logic [N_W-1:0] n, input logic [N_W-1:0] r);
		bc_out_t      res;
		logic [127:0] running;
		int unsigned  nn;
		int unsigned  k;
		nn = 32'(n);
		k = 32'(r);
		res.coefficient = '0;
		if (k > nn) begin
			res.status = ST_R_ABOVE_N;
		end else if (nn > MAX_N) begin
			res.status = ST_N_ABOVE_MAX;
		end else begin
			res.status = ST_OK;
			if (k > nn - k) begin
				k = nn - k;
			end
			running = 128'd1;
			for (int unsigned i = 0; i < k; i++) begin
				running = running * (nn - i) / (i + 1);
			end
			// keep only the field width, as the block does for a raised MAX_N
			res.coefficient = running[COEFF_W-1:0];
		end
		return res;
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned idle_cycles();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("[%0t] %s", $realtime, what);
		end
	endtask

	// Send one request and log its expected result once the transaction is taken.
	// Hold valid high across back-to-back requests so it is never lowered and
	// raised again within one time step.
	task automatic send_request(input logic [N_W-1:0] n, input logic [N_W-1:0] r);
		int unsigned gap;
		pending_t    entry;
		gap = no_idle ? 0 : idle_cycles();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.n_items <= n;
		req.chosen  <= r;
		req_valid   <= 1'b1;
		do begin
			@(posedge clk);
		end while (!req_ready);
		entry.item.n_items = n;
		entry.item.chosen  = r;
		entry.result       = binomial_of(n, r);
		pending_coefficients.push_back(entry);
	endtask

	// r = 0 and r = n give 1 without running a single round
	task automatic test_trivial_counts();
		send_request(6'd0, 6'd0);
		send_request(6'd1, 6'd0);
		send_request(6'd1, 6'd1);
		send_request(6'(MAX_N), 6'd0);
		send_request(6'(MAX_N), 6'(MAX_N));
		send_request(6'd37, 6'd0);
		send_request(6'd37, 6'd37);
	endtask

	// Counts above n / 2 fold over to n - r; include the largest result, C(60, 30)
	task automatic test_count_folding();
		send_request(6'd10, 6'd3);
		send_request(6'd10, 6'd7);
		send_request(6'd2, 6'd1);
		send_request(6'(MAX_N), 6'd1);
		send_request(6'(MAX_N), 6'(MAX_N - 1));
		send_request(6'(MAX_N), 6'(MAX_N / 2));
		send_request(6'd59, 6'd29);
		send_request(6'd59, 6'd30);
	endtask

	// r above n, n above the limit, and both at once (r above n wins)
	task automatic test_error_status();
		send_request(6'd5, 6'd6);
		send_request(6'd0, 6'd63);
		send_request(6'(MAX_N + 1), 6'd0);
		send_request(6'd63, 6'd63);
		send_request(6'd62, 6'd5);
		send_request(6'(MAX_N + 1), 6'(MAX_N + 2));
		send_request(6'd63, 6'd0);
	endtask

	// Mostly legal requests; the rest are error cases and raw noise over all 12 bits.
	// Alternate stretches of full-rate traffic with stretches of random idling.
	task automatic test_random_requests(input int count);
		int unsigned      pick;
		logic [N_W-1:0]   n;
		logic [N_W-1:0]   r;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0) begin
				no_idle = (i == 0) || ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = N_W'($urandom_range(0, MAX_N));
				r = N_W'($urandom_range(0, 32'(n)));
			end else if (pick < 80) begin
				n = N_W'($urandom_range(0, 62));
				r = N_W'($urandom_range(32'(n) + 1, 63));
			end else if (pick < 90) begin
				n = N_W'($urandom_range(MAX_N + 1, 63));
				r = N_W'($urandom_range(0, 32'(n)));
			end else begin
				n = N_W'($urandom_range(0, 63));
				r = N_W'($urandom_range(0, 63));
			end
			send_request(n, r);
		end
		no_idle = 1'b0;
	endtask

	// Result side: stall ready for random stretches, or keep it high while no_idle is set and no stall is pending
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold = ready_hold - 1;
		end else if (no_idle) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(0, 3) != 0);
			ready_hold = idle_cycles();
		end
	end

	// Compare every result transaction with the oldest outstanding expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_coefficients.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: coefficient %0d status %0d",
					rsp.coefficient, rsp.status));
			end else begin
				oldest = pending_coefficients.pop_front();
				if (rsp.coefficient !== oldest.result.coefficient) begin
					flag_mismatch($sformatf("n=%0d r=%0d coefficient: expected %0d, got %0d",
						oldest.item.n_items, oldest.item.chosen,
						oldest.result.coefficient, rsp.coefficient));
				end
				if (rsp.status !== oldest.result.status) begin
					flag_mismatch($sformatf("n=%0d r=%0d status: expected %0d, got %0d",
						oldest.item.n_items, oldest.item.chosen,
						oldest.result.status, rsp.status));
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		// Hold reset, then release it on a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_trivial_counts();
		test_count_folding();
		test_error_status();
		test_random_requests(300);

		// Drop valid after the last transaction, drain, then watch for stray results
		req_valid <= 1'b0;
		while (pending_coefficients.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: binomial_coefficient_core.f
rtl/core/bc_pkg.sv
rtl/core/bc_div.sv
rtl/core/binomial_coefficient_core.sv
rtl/core/bc_checker.sv
sim/tb_binomial_coefficient_core.sv
